// ===== hw/rtl/zccr_pkg.sv =====
package zccr_pkg;

	localparam int GAIN_W     = 16;
	localparam int GAIN_SHIFT = 15;
	localparam int ROUND_HALF = 1 << (GAIN_SHIFT - 1);
	localparam int CFG_IDX_W  = 1;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'h8000;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_INPUT_GAIN = 1'b0;
	localparam cfg_idx_t REG_CYCLE_GAIN = 1'b1;

	// per-stage control that travels with a sample
	typedef struct packed {
		logic valid;
		logic play;
	} ctl_t;

endpackage

// ===== hw/rtl/zero_cross_cycle_capture_replay.sv =====
// Zero-crossing cycle capture and replay.
// Slave stream (s_axis_*) takes one signed sample per request; the master stream
// (m_axis_*) returns exactly one mixed sample per request, in order, with
// m_axis_tuser set when a stored sample was mixed in. Gains are written through
// cfg_we/cfg_addr/cfg_wdata: index 0 input gain, index 1 cycle gain (Q1.15).
// The captured cycle lives in a STORE_DEPTH-entry single-clock RAM: capture
// writes one entry per request once a rising crossing is seen, replay reads one
// entry per request with the RAM's registered read port as pipeline stage 1.
// Throughput: one request per cycle while the output is not stalled. A request
// passes the RAM read register, the product register and the output register.
// When the output register is full and m_axis_tready is low, the whole pipeline
// holds and s_axis_tready drops; it rises again in the cycle the output is taken.
// Reset clears the pipeline valids, returns to capture mode with an empty store,
// zeroes the previous sample and sets both gains to unity. Store contents are not
// cleared; replay only reads entries written during the preceding capture.
module zero_cross_cycle_capture_replay #(
	parameter int STORE_DEPTH = 16384,
	parameter int SAMPLE_BITS = 24,
	localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [DATA_W-1:0]                 s_axis_tdata,  // sample_in
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [DATA_W-1:0]                 m_axis_tdata,  // sample_out
	output logic                              m_axis_tuser,  // replaying
	input  logic                              cfg_we,
	input  zccr_pkg::cfg_idx_t                cfg_addr,
	input  logic [zccr_pkg::GAIN_W-1:0]       cfg_wdata
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);

	logic [SAMPLE_BITS-1:0]        mem [STORE_DEPTH];

	logic [zccr_pkg::GAIN_W-1:0]   input_gain_q;
	logic [zccr_pkg::GAIN_W-1:0]   cycle_gain_q;
	logic [CW-1:0]                 wc_q, wc_d, wc_inc, ri_inc;
	logic [AW-1:0]                 ri_q, ri_d;
	logic                          replay_q, replay_d;
	logic [SAMPLE_BITS-1:0]        prev_q;

	logic                          advance;
	logic                          accept;
	logic [SAMPLE_BITS-1:0]        x;
	logic                          rising;
	logic                          wr_en;
	logic                          rd_en;
	logic [SAMPLE_BITS-1:0]        wr_data;

	zccr_pkg::ctl_t                ctl_s1;
	logic [SAMPLE_BITS-1:0]        x_s1;
	logic [SAMPLE_BITS-1:0]        rdata_s1;
	logic [SAMPLE_BITS-1:0]        out_sample;

	assign accept        = s_axis_tvalid && advance;
	assign s_axis_tready = advance;
	assign x             = s_axis_tdata[SAMPLE_BITS-1:0];
	assign rising        = prev_q[SAMPLE_BITS-1] && !x[SAMPLE_BITS-1];
	assign wc_inc        = wc_q + CW'(1);
	assign ri_inc        = CW'(ri_q) + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_gain_q <= zccr_pkg::GAIN_RESET;
			cycle_gain_q <= zccr_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				zccr_pkg::REG_INPUT_GAIN: input_gain_q <= cfg_wdata;
				zccr_pkg::REG_CYCLE_GAIN: cycle_gain_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		wc_d     = wc_q;
		ri_d     = ri_q;
		replay_d = replay_q;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		wr_data  = x;
		if (accept) begin
			if (!replay_q) begin
				if (wc_q == '0) begin
					// waiting: the crossing sample becomes entry 0
					if (rising) begin
						wr_en = 1'b1;
						wc_d  = CW'(1);
					end
				end else if (!rising) begin
					wr_en = 1'b1;
					wc_d  = wc_inc;
					if (wc_inc == CW'(STORE_DEPTH)) begin
						replay_d = 1'b1;
					end
				end else begin
					// closing crossing stores a zero in place of the sample
					wr_en    = 1'b1;
					wr_data  = '0;
					wc_d     = wc_inc;
					replay_d = 1'b1;
				end
			end else begin
				rd_en = 1'b1;
				if (ri_inc >= wc_q) begin
					wc_d     = '0;
					ri_d     = '0;
					replay_d = 1'b0;
				end else begin
					ri_d = ri_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q     <= '0;
			ri_q     <= '0;
			replay_q <= 1'b0;
			prev_q   <= '0;
		end else if (accept) begin
			wc_q     <= wc_d;
			ri_q     <= ri_d;
			replay_q <= replay_d;
			prev_q   <= x;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wc_q[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[ri_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (advance) begin
			ctl_s1.valid <= accept;
			ctl_s1.play  <= accept && replay_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= x;
		end
	end

	zccr_mix #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s1     (ctl_s1),
		.live_s1    (x_s1),
		.stored_s1  (rdata_s1),
		.input_gain (input_gain_q),
		.cycle_gain (cycle_gain_q),
		.out_ready  (m_axis_tready),
		.advance    (advance),
		.out_valid  (m_axis_tvalid),
		.out_sample (out_sample),
		.out_play   (m_axis_tuser)
	);

	assign m_axis_tdata = DATA_W'(out_sample);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wc_q <= CW'(STORE_DEPTH))
		else $error("store count beyond depth");

	a_replay_index: assert property (@(posedge clk) disable iff (!arst_n)
		replay_q |-> (wc_q != '0) && (CW'(ri_q) < wc_q))
		else $error("replay index outside captured cycle");

	a_no_write_in_replay: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !replay_q && accept && !rd_en)
		else $error("store write outside capture");

	a_play_tracks_read: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && replay_q) |=> ctl_s1.valid && ctl_s1.play)
		else $error("replay request lost its stored sample");

endmodule

// ===== hw/rtl/zccr_mix.sv =====
module zccr_mix #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  zccr_pkg::ctl_t                ctl_s1,
	input  logic [SAMPLE_BITS-1:0]        live_s1,
	input  logic [SAMPLE_BITS-1:0]        stored_s1,
	input  logic [zccr_pkg::GAIN_W-1:0]   input_gain,
	input  logic [zccr_pkg::GAIN_W-1:0]   cycle_gain,
	input  logic                          out_ready,
	output logic                          advance,
	output logic                          out_valid,
	output logic [SAMPLE_BITS-1:0]        out_sample,
	output logic                          out_play
);

	localparam int PW = SAMPLE_BITS + zccr_pkg::GAIN_W + 1;
	localparam int SW = PW + 1;
	localparam int QW = SW - zccr_pkg::GAIN_SHIFT;

	zccr_pkg::ctl_t          ctl_s2;
	logic signed [PW-1:0]    live_prod_s2;
	logic signed [PW-1:0]    cyc_prod_s2;
	logic signed [SAMPLE_BITS-1:0] stored_term;
	logic signed [SW-1:0]    sum;
	logic signed [QW-1:0]    quot;
	logic [QW-SAMPLE_BITS:0] upper;
	logic [SAMPLE_BITS-1:0]  sat;
	logic                    out_valid_q;
	logic [SAMPLE_BITS-1:0]  out_sample_q;
	logic                    out_play_q;

	assign advance     = !out_valid_q || out_ready;
	assign stored_term = ctl_s1.play ? $signed(stored_s1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (advance) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			live_prod_s2 <= $signed(live_s1) * $signed({1'b0, input_gain});
			cyc_prod_s2  <= stored_term * $signed({1'b0, cycle_gain});
		end
	end

	// round half up, then clamp to the sample range
	always_comb begin
		sum   = SW'(live_prod_s2) + SW'(cyc_prod_s2) + SW'(zccr_pkg::ROUND_HALF);
		quot  = QW'(sum >>> zccr_pkg::GAIN_SHIFT);
		upper = quot[QW-1:SAMPLE_BITS-1];
		if ((&upper) || !(|upper)) begin
			sat = quot[SAMPLE_BITS-1:0];
		end else if (quot[QW-1]) begin
			sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ctl_s2.valid) begin
			out_sample_q <= sat;
			out_play_q   <= ctl_s2.play;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign out_play   = out_play_q;

endmodule
